@@ design/lsdt_pkg.sv @@
package lsdt_pkg;

	localparam int DIM          = 4;
	localparam int MAX_VERTICES = 16;
	localparam int COORD_FIELDS = 4;
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = DIFF_W + COORD_W;
	// four products at most, so two guard bits cover the sum
	localparam int SUM_W        = PROD_W + 2;
	localparam int VERT_W       = DIM * COORD_W;
	localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef struct packed {
		logic [1:0] mode;
		coord_t     corner_x0;
		coord_t     corner_x1;
		coord_t     corner_x2;
		coord_t     corner_x3;
		coord_t     point_x0;
		coord_t     point_x1;
		coord_t     point_x2;
		coord_t     point_x3;
	} cmd_item_t;

	typedef struct packed {
		logic dominates;
		logic store_full;
	} res_item_t;

	// per-vertex compare result from the score pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic gt;
		logic lt;
	} cmp_t;

endpackage

@@ design/lsdt_cmd_if.sv @@
interface lsdt_cmd_if;
	import lsdt_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/lsdt_res_if.sv @@
interface lsdt_res_if;
	import lsdt_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/linear_score_dominance_test.sv @@
// Linear-score dominance test over a stored set of weight vertices.
//
// cmd channel: one transaction per item. mode selects clear, append (vertex
// taken from the corner fields) or query (corner against point). res
// channel: exactly one transaction per cmd item, in order.
//
// Sequencing: clear, append, unused mode and a query on an empty set go
// from acceptance to the done state, where their result is registered
// once the output register is free; the next item is taken after that,
// back in idle. A query over N stored vertices streams one vertex per
// cycle out of the vertex RAM (one read port), then through a multiply
// stage and a sum/compare stage; its result is registered in the done
// state after the last compare, and the block takes no new item until
// that result is registered.
//
// Reset clears the vertex count and all handshake state; the vertex RAM
// holds no reset value and is never read past the count.
// A stalled res channel holds its result in the output register; one more
// item is accepted and processed, then the block waits until that register
// frees up.
module linear_score_dominance_test (
	input  logic       clk,
	input  logic       arst_n,
	lsdt_cmd_if.sink   cmd,
	lsdt_res_if.source res
);
	import lsdt_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;   // vertices held
	logic [CNT_W-1:0]  issue_q;   // next vertex to read during a scan
	diff_t             diff_q [DIM];
	logic              strict_q;  // some corner score strictly smaller
	logic              beaten_q;  // some corner score larger
	logic              pend_dom_q;
	logic              pend_full_q;
	logic              rd_vld_s1;
	logic              last_s1;
	logic              res_vld_q;
	res_item_t         res_data_q;

	logic              accept;
	logic              full_c;
	logic              we;
	logic              rd_en;
	logic              load_res;
	logic              scan_end;
	logic              dom_c;
	logic [VERT_W-1:0] wdata;
	logic [VERT_W-1:0] rdata;
	coord_t            corner_c [COORD_FIELDS];
	coord_t            point_c  [COORD_FIELDS];
	cmp_t              cmp;

	assign corner_c[0] = cmd.data.corner_x0;
	assign corner_c[1] = cmd.data.corner_x1;
	assign corner_c[2] = cmd.data.corner_x2;
	assign corner_c[3] = cmd.data.corner_x3;
	assign point_c[0]  = cmd.data.point_x0;
	assign point_c[1]  = cmd.data.point_x1;
	assign point_c[2]  = cmd.data.point_x2;
	assign point_c[3]  = cmd.data.point_x3;

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			wdata[i*COORD_W +: COORD_W] = corner_c[i];
		end
	end

	assign full_c   = (count_q == CNT_W'(MAX_VERTICES));
	assign accept   = cmd.valid && cmd.ready;
	assign we       = accept && (mode_t'(cmd.data.mode) == MODE_APPEND) && !full_c;
	assign scan_end = cmp.valid && cmp.last;
	// any larger corner score rules out dominance; later vertices cannot undo it
	assign dom_c    = !(beaten_q || cmp.gt) && (strict_q || cmp.lt);

	// sequencer
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		rd_en     = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					if ((mode_t'(cmd.data.mode) == MODE_QUERY) && (count_q != '0)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				rd_en = (issue_q < count_q);
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_vld_q || res.ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
			strict_q  <= 1'b0;
			beaten_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (accept) begin
				issue_q  <= '0;
				strict_q <= 1'b0;
				beaten_q <= 1'b0;
				if (mode_t'(cmd.data.mode) == MODE_CLEAR) begin
					count_q <= '0;
				end else if (we) begin
					count_q <= count_q + 1'b1;
				end
			end else begin
				if (rd_en) begin
					issue_q <= issue_q + 1'b1;
				end
				if (cmp.valid) begin
					strict_q <= strict_q || cmp.lt;
					beaten_q <= beaten_q || cmp.gt;
				end
			end
			if (load_res) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		last_s1 <= (issue_q == (count_q - 1'b1));
		if (accept) begin
			for (int i = 0; i < DIM; i++) begin
				diff_q[i] <= DIFF_W'(corner_c[i]) - DIFF_W'(point_c[i]);
			end
			pend_dom_q  <= 1'b0;
			pend_full_q <= (mode_t'(cmd.data.mode) == MODE_APPEND) && full_c;
		end else if ((state_q == ST_SCAN) && scan_end) begin
			pend_dom_q <= dom_c;
		end
		if (load_res) begin
			res_data_q.dominates  <= pend_dom_q;
			res_data_q.store_full <= pend_full_q;
		end
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_data_q;

	lsdt_ram #(
		.WIDTH (VERT_W),
		.DEPTH (MAX_VERTICES)
	) u_vertex_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (issue_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	lsdt_score u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_vld_s1),
		.in_last  (last_s1),
		.vertex   (rdata),
		.diff     (diff_q),
		.cmp      (cmp)
	);

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp.valid |-> (state_q == ST_SCAN))
		else $error("compare result outside a scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count past capacity");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("append did not advance the vertex count");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!rd_vld_s1 && !cmp.valid && !rd_en))
		else $error("scan pipeline busy while a result is pending");

endmodule

@@ design/lsdt_ram.sv @@
module lsdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lsdt_score.sv @@
module lsdt_score (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_last,
	input  logic [lsdt_pkg::VERT_W-1:0] vertex,
	input  lsdt_pkg::diff_t           diff [lsdt_pkg::DIM],
	output lsdt_pkg::cmp_t            cmp
);
	import lsdt_pkg::*;

	// score difference: dot(corner, v) - dot(point, v) = dot(corner - point, v)
	logic signed [PROD_W-1:0] prod_s2 [DIM];
	logic                     vld_s2;
	logic                     last_s2;
	logic signed [SUM_W-1:0]  sum_c;

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIM; i++) begin
			prod_s2[i] <= diff[i] * $signed(vertex[i*COORD_W +: COORD_W]);
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < DIM; i++) begin
			sum_c = sum_c + SUM_W'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			cmp    <= '0;
		end else begin
			vld_s2    <= in_valid;
			cmp.valid <= vld_s2;
			cmp.last  <= last_s2;
			cmp.gt    <= !sum_c[SUM_W-1] && (sum_c != '0);
			cmp.lt    <= sum_c[SUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= in_last;
	end

endmodule
